>>> hdl/tdpt_pkg.sv
// Shared constants for the trial-division prime test block.
`timescale 1ns / 1ps
`default_nettype none
package tdpt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    typedef logic [1:0] t_verdict;

    localparam t_verdict VERDICT_PRIME     = 2'd0;
    localparam t_verdict VERDICT_TOO_SMALL = 2'd1;
    localparam t_verdict VERDICT_COMPOSITE = 2'd2;

endpackage
`default_nettype wire

>>> hdl/trial_division_prime_test_top.sv
// Trial-division prime test: bit-serial restoring divider and trial sequencer.
//
// Slave channel (i_s_*): one two's complement number per transaction.
// Master channel (o_m_*): one verdict per transaction, 0 prime, 1 not above one,
// 2 composite.
// The block works on one number at a time. o_s_tready is high only while the
// sequencer is idle; a finished verdict sits in the output register, so the
// next number is taken while that verdict still waits for i_m_tready.
// Numbers of one or less (negative ones included) go straight to the done state.
// Otherwise each candidate divisor d = 2, 3, ... takes a pass through the
// one-bit-per-cycle divider plus a check state that compares d with the
// quotient and tests the remainder for zero.
// The worst case for 32 bits is a prime near 2^31, which needs 46340 trials.
// A stalled receiver holds the verdict in the output register and the
// sequencer waits in its done state until that register frees up.
// Reset (synchronous, active low) returns to idle and drops o_m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module trial_division_prime_test_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [tdpt_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [W-1:0] number
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [tdpt_pkg::OUT_TDATA_W-1:0]   o_m_tdata    // [1:0] verdict, rest zero
);

    localparam int W = tdpt_pkg::VALUE_WIDTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [W-1:0]              r_num, n_num;
    logic [W-1:0]              r_d, n_d;
    logic [W-1:0]              r_quo, n_quo;
    logic [W-1:0]              r_rem, n_rem;
    logic [tdpt_pkg::CNT_W-1:0] r_cnt, n_cnt;
    tdpt_pkg::t_verdict        r_result, n_result;
    logic                      r_out_valid, n_out_valid;
    tdpt_pkg::t_verdict        r_out_verdict, n_out_verdict;

    logic [W-1:0]  s_num;
    logic          s_small;
    logic [W+1:0]  s_diff;
    logic          s_fits;
    logic          s_in_xfer;
    logic          s_out_free;

    assign s_num      = i_s_tdata[W-1:0];
    assign s_small    = s_num[W-1] | (s_num[W-1:1] == '0);
    assign s_in_xfer  = i_s_tvalid & o_s_tready;
    assign s_out_free = ~r_out_valid | i_m_tready;

    // one restoring step: shift in the next dividend bit, try subtracting d
    assign s_diff = {1'b0, r_rem, r_quo[W-1]} - {2'b00, r_d};
    assign s_fits = ~s_diff[W+1];

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(tdpt_pkg::OUT_TDATA_W-2){1'b0}}, r_out_verdict};

    always_comb begin
        n_state       = r_state;
        n_num         = r_num;
        n_d           = r_d;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_cnt         = r_cnt;
        n_result      = r_result;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_in_xfer) begin
                    n_num = s_num;
                    n_d   = W'(2);
                    n_quo = s_num;
                    n_rem = '0;
                    n_cnt = '0;
                    if (s_small) begin
                        n_result = tdpt_pkg::VERDICT_TOO_SMALL;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_quo = {r_quo[W-2:0], s_fits};
                n_rem = s_fits ? s_diff[W-1:0] : {r_rem[W-2:0], r_quo[W-1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tdpt_pkg::CNT_W'(W - 1)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // bound test first: d > num / d means no divisor is left
                if (r_d > r_quo) begin
                    n_result = tdpt_pkg::VERDICT_PRIME;
                    n_state  = ST_DONE;
                end else if (r_rem == '0) begin
                    n_result = tdpt_pkg::VERDICT_COMPOSITE;
                    n_state  = ST_DONE;
                end else begin
                    n_d     = r_d + 1'b1;
                    n_quo   = r_num;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DONE: begin
                if (s_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_result;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num         <= n_num;
        r_d           <= n_d;
        r_quo         <= n_quo;
        r_rem         <= n_rem;
        r_result      <= n_result;
        r_out_verdict <= n_out_verdict;
    end

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_verdict != 2'd3))
        else $error("illegal verdict code on output");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_xfer |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after an input transaction");

    a_divisor_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) || (r_state == ST_CHECK)) |-> (r_d >= W'(2)))
        else $error("trial divisor below two");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("output loaded outside the done state");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_rem < r_d))
        else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
